>>> hdl/lahf_pkg.sv
// Shared types and constants for the latency-aware host filter.
// Depends on nothing; the top level refers to it by scoped names.
package lahf_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned HOST_W  = 16;
  localparam int unsigned AVG_W   = 63;
  localparam int unsigned MAG_W   = 62;
  localparam int unsigned CNT32_W = 32;
  localparam int unsigned TIME_W  = 63;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned LO_W    = 32;
  localparam int unsigned HI_W    = MAG_W - LO_W;
  localparam int unsigned PROD_W  = THR_W + MAG_W;

  localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd0;
  localparam logic [OP_W-1:0] OP_CANDIDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_END       = 2'd2;

  localparam logic KIND_HOST      = 1'b0;
  localparam logic KIND_EXHAUSTED = 1'b1;

  localparam logic [CIDX_W-1:0] REG_MIN_MEAS  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_RETRY     = 2'd1;
  localparam logic [CIDX_W-1:0] REG_THRESHOLD = 2'd2;

  localparam logic [CNT32_W-1:0] MIN_MEAS_RESET  = 32'd50;
  localparam logic [TIME_W-1:0]  RETRY_RESET     = 63'd10000000000;
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = 16'd512;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL_HI,
    ST_DECIDE,
    ST_DRAIN,
    ST_DRAIN_END
  } state_t;

endpackage

>>> hdl/latency_aware_host_filter.sv
// Top level of the latency-aware host filter: scan minimum, candidate screen, skip memory.
// Depends on lahf_pkg for state type, opcodes, register indexes and field widths.
//
//   channel   signals                                   direction
//   command   start, busy, op .. scan_last              in (busy out)
//   result    strobe, kind, chosen_host, last_of_run    out
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in (ready out)
//
// A sample or end item with an empty store passes EVAL, then IDLE accepts the next item.
// A measured candidate passes EVAL, MUL_HI, DECIDE for a 16x32 and a 16x30 multiply.
// An end item with N deferred hosts does one skip memory read per host, then DRAIN_END.
// Each result word is output in the cycle after it is decided; the receiver cannot stall.
// Reset clears the minimum, the scan and the store count; the skip memory needs no clearing.
module latency_aware_host_filter #(
  parameter int unsigned SKIP_DEPTH   = 16,
  parameter int unsigned HOST_ID_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lahf_pkg::OP_W-1:0]            op,
  input  logic [lahf_pkg::HOST_W-1:0]          host_id,
  input  logic signed [lahf_pkg::AVG_W-1:0]    average_ns,
  input  logic [lahf_pkg::CNT32_W-1:0]         measured_count,
  input  logic [lahf_pkg::TIME_W-1:0]          sample_time_ns,
  input  logic [lahf_pkg::TIME_W-1:0]          now_ns,
  input  logic                                 scan_last,
  output logic                                 strobe,
  output logic                                 kind,
  output logic [lahf_pkg::HOST_W-1:0]          chosen_host,
  output logic                                 last_of_run,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lahf_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [lahf_pkg::TIME_W-1:0]          cfg_data
);

  localparam int unsigned IDX_W = (SKIP_DEPTH > 1) ? $clog2(SKIP_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(SKIP_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SKIP_DEPTH);
  localparam logic [lahf_pkg::HOST_W-1:0] HOST_MASK =
    (HOST_ID_BITS >= lahf_pkg::HOST_W) ? {lahf_pkg::HOST_W{1'b1}} :
    lahf_pkg::HOST_W'((32'd1 << HOST_ID_BITS) - 32'd1);

  lahf_pkg::state_t state, state_next;

  logic [lahf_pkg::CNT32_W-1:0] min_meas;
  logic [lahf_pkg::TIME_W-1:0]  retry_period;
  logic [lahf_pkg::THR_W-1:0]   threshold;

  logic [lahf_pkg::OP_W-1:0]    op_q;
  logic [lahf_pkg::HOST_W-1:0]  host_q;
  logic [lahf_pkg::AVG_W-1:0]   avg_q;
  logic [lahf_pkg::CNT32_W-1:0] count_q;
  logic [lahf_pkg::TIME_W-1:0]  stamp_q;
  logic [lahf_pkg::TIME_W-1:0]  now_q;
  logic                         last_q;

  logic                         min_valid;
  logic [lahf_pkg::MAG_W-1:0]   min_avg;
  logic                         scan_found;
  logic [lahf_pkg::MAG_W-1:0]   scan_min;
  logic [CNT_W-1:0]             skip_count;
  logic [CNT_W-1:0]             idx;

  logic [lahf_pkg::HOST_W-1:0]  skip_mem [SKIP_DEPTH];
  logic [lahf_pkg::HOST_W-1:0]  rd_data;
  logic [IDX_W-1:0]             rd_addr;
  logic                         rd_en;
  logic                         wr_en;

  logic [lahf_pkg::THR_W+lahf_pkg::LO_W-1:0] prod_lo;
  logic [lahf_pkg::THR_W+lahf_pkg::HI_W-1:0] prod_hi;
  logic [lahf_pkg::PROD_W-1:0]  prod_sum;
  logic [lahf_pkg::PROD_W-1:0]  avg_scaled;
  logic                         within_limit;

  logic [lahf_pkg::TIME_W-1:0]  age;
  logic                         fresh;
  logic                         qualifies;
  logic                         avg_neg;

  logic                         emit;
  logic                         emit_kind;
  logic [lahf_pkg::HOST_W-1:0]  emit_host;
  logic                         emit_last;

  assign busy      = (state != lahf_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign avg_neg   = avg_q[lahf_pkg::AVG_W-1];
  assign age       = now_q - stamp_q;
  assign fresh     = (stamp_q <= now_q) && (age <= retry_period);
  assign qualifies = !avg_neg && (count_q >= min_meas) && fresh;

  assign prod_sum   = {prod_hi, {lahf_pkg::LO_W{1'b0}}}
                    + lahf_pkg::PROD_W'(prod_lo);
  assign avg_scaled = lahf_pkg::PROD_W'({avg_q[lahf_pkg::MAG_W-1:0], 8'b0});
  assign within_limit = (avg_scaled <= prod_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_meas     <= lahf_pkg::MIN_MEAS_RESET;
      retry_period <= lahf_pkg::RETRY_RESET;
      threshold    <= lahf_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lahf_pkg::REG_MIN_MEAS:  min_meas     <= cfg_data[lahf_pkg::CNT32_W-1:0];
        lahf_pkg::REG_RETRY:     retry_period <= cfg_data;
        lahf_pkg::REG_THRESHOLD: threshold    <= cfg_data[lahf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lahf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_kind  = lahf_pkg::KIND_HOST;
    emit_host  = host_q;
    emit_last  = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = idx[IDX_W-1:0];
    wr_en      = 1'b0;
    case (state)
      lahf_pkg::ST_IDLE: begin
        if (start) begin
          state_next = lahf_pkg::ST_EVAL;
        end
      end
      lahf_pkg::ST_EVAL: begin
        state_next = lahf_pkg::ST_IDLE;
        case (op_q)
          lahf_pkg::OP_CANDIDATE: begin
            if (!min_valid || !qualifies) begin
              emit = 1'b1;
            end else begin
              state_next = lahf_pkg::ST_MUL_HI;
            end
          end
          lahf_pkg::OP_END: begin
            if (skip_count == '0) begin
              emit      = 1'b1;
              emit_kind = lahf_pkg::KIND_EXHAUSTED;
              emit_host = '0;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = '0;
              state_next = lahf_pkg::ST_DRAIN;
            end
          end
          default: ;
        endcase
      end
      lahf_pkg::ST_MUL_HI: begin
        state_next = lahf_pkg::ST_DECIDE;
      end
      lahf_pkg::ST_DECIDE: begin
        state_next = lahf_pkg::ST_IDLE;
        if (within_limit || (skip_count == DEPTH_CNT)) begin
          emit = 1'b1;
        end else begin
          wr_en = 1'b1;
        end
      end
      lahf_pkg::ST_DRAIN: begin
        emit      = 1'b1;
        emit_host = rd_data;
        emit_last = 1'b0;
        if (idx == skip_count) begin
          state_next = lahf_pkg::ST_DRAIN_END;
        end else begin
          rd_en = 1'b1;
        end
      end
      lahf_pkg::ST_DRAIN_END: begin
        emit       = 1'b1;
        emit_kind  = lahf_pkg::KIND_EXHAUSTED;
        emit_host  = '0;
        state_next = lahf_pkg::ST_IDLE;
      end
      default: begin
        state_next = lahf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == lahf_pkg::ST_IDLE && start) begin
      op_q    <= op;
      host_q  <= host_id & HOST_MASK;
      avg_q   <= average_ns;
      count_q <= measured_count;
      stamp_q <= sample_time_ns;
      now_q   <= now_ns;
      last_q  <= scan_last;
    end
    if (state == lahf_pkg::ST_EVAL) begin
      prod_lo <= {{lahf_pkg::LO_W{1'b0}}, threshold}
               * {{lahf_pkg::THR_W{1'b0}}, min_avg[lahf_pkg::LO_W-1:0]};
    end
    if (state == lahf_pkg::ST_MUL_HI) begin
      prod_hi <= {{lahf_pkg::HI_W{1'b0}}, threshold}
               * {{lahf_pkg::THR_W{1'b0}}, min_avg[lahf_pkg::MAG_W-1:lahf_pkg::LO_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      skip_mem[skip_count[IDX_W-1:0]] <= host_q;
    end
    if (rd_en) begin
      rd_data <= skip_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_valid  <= 1'b0;
      min_avg    <= '0;
      scan_found <= 1'b0;
      scan_min   <= '0;
      skip_count <= '0;
      idx        <= '0;
    end else begin
      if (state == lahf_pkg::ST_EVAL && op_q == lahf_pkg::OP_SAMPLE) begin
        if (last_q) begin
          if (qualifies || scan_found) begin
            min_valid <= 1'b1;
            if (qualifies && (!scan_found ||
                avg_q[lahf_pkg::MAG_W-1:0] < scan_min)) begin
              min_avg <= avg_q[lahf_pkg::MAG_W-1:0];
            end else begin
              min_avg <= scan_min;
            end
          end
          scan_found <= 1'b0;
        end else if (qualifies) begin
          scan_found <= 1'b1;
          if (!scan_found || avg_q[lahf_pkg::MAG_W-1:0] < scan_min) begin
            scan_min <= avg_q[lahf_pkg::MAG_W-1:0];
          end
        end
      end
      if (state == lahf_pkg::ST_EVAL) begin
        idx <= CNT_W'(1);
      end else if (state == lahf_pkg::ST_DRAIN) begin
        idx <= idx + CNT_W'(1);
      end
      if (wr_en) begin
        skip_count <= skip_count + CNT_W'(1);
      end else if (state == lahf_pkg::ST_DRAIN_END) begin
        skip_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
    kind        <= emit_kind;
    chosen_host <= emit_host;
    last_of_run <= emit_last;
  end

endmodule
